FILE: design/go_to_point_heading_controller_unit_defines.svh
`ifndef GO_TO_POINT_HEADING_CONTROLLER_UNIT_DEFINES_SVH
`define GO_TO_POINT_HEADING_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GTPHC_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define GTPHC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/gtphc_pkg.sv
`timescale 1ns / 1ps

package gtphc_pkg;

	localparam int POS_W  = 32;
	localparam int DIFF_W = 33;
	// cordic datapath, room for gain of about 1.65 times sqrt(2) over a 33-bit vector
	localparam int XY_W   = 36;
	// q3.29 angle accumulator
	localparam int ANG_W  = 32;
	localparam int HDG_W  = 16;
	localparam int ERR_W  = 18;
	localparam int CMD_W  = 16;
	localparam int SPD_W  = 15;
	localparam int DTOL_W = 31;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic signed [ANG_W-1:0] HALF_PI_Q29 = 32'sd843314856;
	localparam logic signed [ANG_W-1:0] ROUND_Q16   = 32'sd32768;
	localparam logic signed [ERR_W-1:0] PI_Q13      = 18'sd25736;
	localparam logic signed [ERR_W-1:0] NEG_PI_Q13  = -18'sd25736;
	localparam logic signed [ERR_W-1:0] TWO_PI_Q13  = 18'sd51472;

	localparam logic [1:0] ACT_START  = 2'd0;
	localparam logic [1:0] ACT_TICK   = 2'd1;
	localparam logic [1:0] ACT_CANCEL = 2'd2;

	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_TURN  = 2'd1;
	localparam logic [1:0] MODE_DRIVE = 2'd2;

	localparam logic [1:0] OUTCOME_NONE     = 2'd0;
	localparam logic [1:0] OUTCOME_REACHED  = 2'd1;
	localparam logic [1:0] OUTCOME_CANCELED = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_GOAL_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GOAL_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HDG_TOL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIST_TOL  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TURN_SPD  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FWD_SPD   = 3'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                    v;
		logic signed [XY_W-1:0]  x;
		logic signed [XY_W-1:0]  y;
		logic signed [ANG_W-1:0] z;
	} cordic_vec_t;

	// atan(2^-i) in q3.29
	function automatic logic signed [ANG_W-1:0] atan_q29(input logic [4:0] idx);
		case (idx)
			5'd0:  return 32'sd421657428;
			5'd1:  return 32'sd248918915;
			5'd2:  return 32'sd131521918;
			5'd3:  return 32'sd66762579;
			5'd4:  return 32'sd33510843;
			5'd5:  return 32'sd16771758;
			5'd6:  return 32'sd8387925;
			5'd7:  return 32'sd4194219;
			5'd8:  return 32'sd2097141;
			5'd9:  return 32'sd1048575;
			5'd10: return 32'sd524288;
			5'd11: return 32'sd262144;
			5'd12: return 32'sd131072;
			5'd13: return 32'sd65536;
			5'd14: return 32'sd32768;
			5'd15: return 32'sd16384;
			5'd16: return 32'sd8192;
			5'd17: return 32'sd4096;
			5'd18: return 32'sd2048;
			5'd19: return 32'sd1024;
			5'd20: return 32'sd512;
			5'd21: return 32'sd256;
			5'd22: return 32'sd128;
			5'd23: return 32'sd64;
			default: return '0;
		endcase
	endfunction

endpackage

FILE: design/gtphc_cordic_cell.sv
`timescale 1ns / 1ps

module gtphc_cordic_cell #(
	parameter int unsigned STEP = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gtphc_pkg::cordic_vec_t vec_in,
	output gtphc_pkg::cordic_vec_t vec_out
);

	localparam int XY_W  = gtphc_pkg::XY_W;
	localparam int ANG_W = gtphc_pkg::ANG_W;
	localparam logic signed [ANG_W-1:0] ATAN = gtphc_pkg::atan_q29(5'(STEP));

	logic signed [XY_W-1:0]  x_in, y_in, x_sh, y_sh, x_n, y_n;
	logic signed [ANG_W-1:0] z_in, z_n;
	logic                    y_pos;

	logic                    v_q;
	logic signed [XY_W-1:0]  x_q, y_q;
	logic signed [ANG_W-1:0] z_q;

	always_comb begin
		x_in  = $signed(vec_in.x);
		y_in  = $signed(vec_in.y);
		z_in  = $signed(vec_in.z);
		x_sh  = x_in >>> STEP;
		y_sh  = y_in >>> STEP;
		y_pos = (y_in > 0);
		// rotate toward the x axis
		if (y_pos) begin
			x_n = x_in + y_sh;
			y_n = y_in - x_sh;
			z_n = z_in + ATAN;
		end else begin
			x_n = x_in - y_sh;
			y_n = y_in + x_sh;
			z_n = z_in - ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= vec_in.v;
		end
	end

	always_ff @(posedge clk) begin
		x_q <= x_n;
		y_q <= y_n;
		z_q <= z_n;
	end

	always_comb begin
		vec_out.v = v_q;
		vec_out.x = x_q;
		vec_out.y = y_q;
		vec_out.z = z_q;
	end

endmodule

FILE: design/gtphc_range_check.sv
`timescale 1ns / 1ps

module gtphc_range_check (
	input  logic                                clk,
	input  logic signed [gtphc_pkg::DIFF_W-1:0] dx,
	input  logic signed [gtphc_pkg::DIFF_W-1:0] dy,
	input  logic        [gtphc_pkg::DTOL_W-1:0] dist_tol,
	output logic                                reached
);

	localparam int MAG_W = gtphc_pkg::POS_W;
	localparam int SQ_W  = 2 * MAG_W;
	localparam int TSQ_W = 2 * gtphc_pkg::DTOL_W;
	localparam int SUM_W = SQ_W + 1;

	logic [MAG_W-1:0] ax_s1, ay_s1;
	logic [SQ_W-1:0]  sqx_s2, sqy_s2;
	logic [TSQ_W-1:0] tsq_s2, tsq_s3;
	logic [SUM_W-1:0] sum_s3;
	logic             reached_q;

	// |dx| stays below 2^32, so 32 bits hold it
	always_ff @(posedge clk) begin
		ax_s1     <= (dx < 0) ? MAG_W'(-dx) : MAG_W'(dx);
		ay_s1     <= (dy < 0) ? MAG_W'(-dy) : MAG_W'(dy);
		sqx_s2    <= SQ_W'(ax_s1) * SQ_W'(ax_s1);
		sqy_s2    <= SQ_W'(ay_s1) * SQ_W'(ay_s1);
		tsq_s2    <= TSQ_W'(dist_tol) * TSQ_W'(dist_tol);
		sum_s3    <= SUM_W'(sqx_s2) + SUM_W'(sqy_s2);
		tsq_s3    <= tsq_s2;
		reached_q <= (sum_s3 <= SUM_W'(tsq_s3));
	end

	assign reached = reached_q;

endmodule

FILE: design/go_to_point_heading_controller_unit.sv
// tick while armed: item goes through launch, pre-rotation, the cordic cells, error and wrap
// registers, then the output register; start, cancel, tick while idle go to the output register
// one item in flight; next item taken the cycle after the result reaches the output
// register, as the fsm returns to idle when the result is loaded
// arst_n clears handshake state, active flag and drive mode, and loads config defaults
`timescale 1ns / 1ps
`include "go_to_point_heading_controller_unit_defines.svh"

module go_to_point_heading_controller_unit #(
	parameter int unsigned CORDIC_STEPS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic        [gtphc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic        [gtphc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic        [1:0]                       action,
	input  logic signed [gtphc_pkg::POS_W-1:0]      pos_x,
	input  logic signed [gtphc_pkg::POS_W-1:0]      pos_y,
	input  logic signed [gtphc_pkg::HDG_W-1:0]      heading,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [gtphc_pkg::CMD_W-1:0]      linear_cmd,
	output logic signed [gtphc_pkg::CMD_W-1:0]      angular_cmd,
	output logic        [1:0]                       mode,
	output logic        [1:0]                       outcome,
	output logic signed [gtphc_pkg::HDG_W-1:0]      heading_error
);

	localparam int POS_W  = gtphc_pkg::POS_W;
	localparam int DIFF_W = gtphc_pkg::DIFF_W;
	localparam int XY_W   = gtphc_pkg::XY_W;
	localparam int ANG_W  = gtphc_pkg::ANG_W;
	localparam int HDG_W  = gtphc_pkg::HDG_W;
	localparam int ERR_W  = gtphc_pkg::ERR_W;
	localparam int CMD_W  = gtphc_pkg::CMD_W;
	localparam int SPD_W  = gtphc_pkg::SPD_W;
	localparam int DTOL_W = gtphc_pkg::DTOL_W;
	localparam int TOK_W  = CORDIC_STEPS + 4;

	// configuration
	logic signed [POS_W-1:0]  goal_x_q, goal_y_q;
	logic        [SPD_W-1:0]  hdg_tol_q, turn_spd_q, fwd_spd_q;
	logic        [DTOL_W-1:0] dist_tol_q;

	// control
	gtphc_pkg::state_t state_q, state_n;
	logic              active_q, active_n;
	logic [1:0]        drive_mode_q, mode_n;
	logic              accept, out_load, launch_q, reached;

	// captured item
	logic [1:0]               act_q;
	logic signed [HDG_W-1:0]  hd_q;
	logic signed [DIFF_W-1:0] dx_q, dy_q;

	// cordic row
	logic signed [XY_W-1:0]  dxe, dye, pre_x, pre_y;
	logic signed [ANG_W-1:0] pre_z;
	logic                    pre_v_q;
	logic signed [XY_W-1:0]  pre_x_q, pre_y_q;
	logic signed [ANG_W-1:0] pre_z_q;
	gtphc_pkg::cordic_vec_t  chain [CORDIC_STEPS+1];
	logic [TOK_W-1:0]        tok_v;

	// bearing and wrap
	logic signed [ANG_W-1:0] z_round;
	logic signed [HDG_W-1:0] bearing;
	logic signed [ERR_W-1:0] w1, w2, w3, w4;
	logic                    er_v_s1, ew_v_s2;
	logic signed [ERR_W-1:0] er_s1;
	logic signed [HDG_W-1:0] ew_s2;

	// result
	logic        [HDG_W-1:0] err_mag;
	logic signed [CMD_W-1:0] res_lin, res_ang, turn_cmd;
	logic signed [HDG_W-1:0] res_err;
	logic [1:0]              res_outcome;

	logic signed [CMD_W-1:0] lin_q, ang_q;
	logic [1:0]              mode_q, outcome_q;
	logic signed [HDG_W-1:0] err_q;
	logic                    out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			goal_x_q   <= '0;
			goal_y_q   <= '0;
			hdg_tol_q  <= 15'd286;
			dist_tol_q <= 31'd3277;
			turn_spd_q <= 15'd166;
			fwd_spd_q  <= 15'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				gtphc_pkg::REG_GOAL_X:   goal_x_q   <= cfg_data;
				gtphc_pkg::REG_GOAL_Y:   goal_y_q   <= cfg_data;
				gtphc_pkg::REG_HDG_TOL:  hdg_tol_q  <= cfg_data[SPD_W-1:0];
				gtphc_pkg::REG_DIST_TOL: dist_tol_q <= cfg_data[DTOL_W-1:0];
				gtphc_pkg::REG_TURN_SPD: turn_spd_q <= cfg_data[SPD_W-1:0];
				gtphc_pkg::REG_FWD_SPD:  fwd_spd_q  <= cfg_data[SPD_W-1:0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			gtphc_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (action == gtphc_pkg::ACT_TICK && active_q) begin
						state_n = gtphc_pkg::ST_RUN;
					end else begin
						state_n = gtphc_pkg::ST_DONE;
					end
				end
			end
			gtphc_pkg::ST_RUN: begin
				if (ew_v_s2) begin
					state_n = gtphc_pkg::ST_DONE;
				end
			end
			gtphc_pkg::ST_DONE: begin
				if (out_load) begin
					state_n = gtphc_pkg::ST_IDLE;
				end
			end
			default: state_n = gtphc_pkg::ST_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		in_ready = (state_q == gtphc_pkg::ST_IDLE);
		out_load = (state_q == gtphc_pkg::ST_DONE) && (!out_valid_q || out_ready);
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= gtphc_pkg::ST_IDLE;
			active_q     <= 1'b0;
			drive_mode_q <= gtphc_pkg::MODE_IDLE;
			launch_q     <= 1'b0;
			pre_v_q      <= 1'b0;
			er_v_s1      <= 1'b0;
			ew_v_s2      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q  <= state_n;
			launch_q <= accept && (action == gtphc_pkg::ACT_TICK) && active_q;
			pre_v_q  <= launch_q;
			er_v_s1  <= chain[CORDIC_STEPS].v;
			ew_v_s2  <= er_v_s1;
			if (out_load) begin
				active_q     <= active_n;
				drive_mode_q <= mode_n;
				out_valid_q  <= 1'b1;
			end else if (out_ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			hd_q  <= heading;
			dx_q  <= DIFF_W'(goal_x_q) - DIFF_W'(pos_x);
			dy_q  <= DIFF_W'(goal_y_q) - DIFF_W'(pos_y);
		end
	end

	gtphc_range_check u_range (
		.clk      (clk),
		.dx       (dx_q),
		.dy       (dy_q),
		.dist_tol (dist_tol_q),
		.reached  (reached)
	);

	// fold the left half plane by a quarter turn
	always_comb begin
		dxe = XY_W'(dx_q);
		dye = XY_W'(dy_q);
		if (dxe < 0) begin
			if (dye >= 0) begin
				pre_x = dye;
				pre_y = -dxe;
				pre_z = gtphc_pkg::HALF_PI_Q29;
			end else begin
				pre_x = -dye;
				pre_y = dxe;
				pre_z = -gtphc_pkg::HALF_PI_Q29;
			end
		end else begin
			pre_x = dxe;
			pre_y = dye;
			pre_z = '0;
		end
	end

	always_ff @(posedge clk) begin
		pre_x_q <= pre_x;
		pre_y_q <= pre_y;
		pre_z_q <= pre_z;
	end

	always_comb begin
		chain[0].v = pre_v_q;
		chain[0].x = pre_x_q;
		chain[0].y = pre_y_q;
		chain[0].z = pre_z_q;
	end

	assign tok_v[0] = chain[0].v;

	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_stage
		gtphc_cordic_cell #(
			.STEP (k)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.vec_in  (chain[k]),
			.vec_out (chain[k+1])
		);
		assign tok_v[k+1] = chain[k+1].v;
	end

	assign tok_v[CORDIC_STEPS+1] = er_v_s1;
	assign tok_v[CORDIC_STEPS+2] = ew_v_s2;
	assign tok_v[CORDIC_STEPS+3] = launch_q;

	// round q3.29 to q3.13, half up
	always_comb begin
		z_round = $signed(chain[CORDIC_STEPS].z) + gtphc_pkg::ROUND_Q16;
		bearing = z_round[ANG_W-1:ANG_W-HDG_W];
	end

	always_comb begin
		w1 = (er_s1 > gtphc_pkg::PI_Q13) ? er_s1 - gtphc_pkg::TWO_PI_Q13 : er_s1;
		w2 = (w1 > gtphc_pkg::PI_Q13) ? w1 - gtphc_pkg::TWO_PI_Q13 : w1;
		w3 = (w2 < gtphc_pkg::NEG_PI_Q13) ? w2 + gtphc_pkg::TWO_PI_Q13 : w2;
		w4 = (w3 < gtphc_pkg::NEG_PI_Q13) ? w3 + gtphc_pkg::TWO_PI_Q13 : w3;
	end

	always_ff @(posedge clk) begin
		er_s1 <= ERR_W'(bearing) - ERR_W'(hd_q);
		ew_s2 <= w4[HDG_W-1:0];
	end

	// result of the captured item
	always_comb begin
		err_mag     = ew_s2[HDG_W-1] ? HDG_W'(-ew_s2) : HDG_W'(ew_s2);
		turn_cmd    = $signed({1'b0, turn_spd_q});
		res_lin     = '0;
		res_ang     = '0;
		res_err     = '0;
		res_outcome = gtphc_pkg::OUTCOME_NONE;
		active_n    = active_q;
		mode_n      = drive_mode_q;
		case (act_q)
			gtphc_pkg::ACT_START: begin
				active_n = 1'b1;
				mode_n   = gtphc_pkg::MODE_IDLE;
			end
			gtphc_pkg::ACT_TICK: begin
				if (active_q) begin
					if (reached) begin
						active_n    = 1'b0;
						mode_n      = gtphc_pkg::MODE_IDLE;
						res_outcome = gtphc_pkg::OUTCOME_REACHED;
					end else begin
						res_err = ew_s2;
						if (err_mag > {1'b0, hdg_tol_q}) begin
							mode_n  = gtphc_pkg::MODE_TURN;
							res_ang = (ew_s2 > 0) ? turn_cmd : -turn_cmd;
						end else begin
							mode_n  = gtphc_pkg::MODE_DRIVE;
							res_lin = $signed({1'b0, fwd_spd_q});
						end
					end
				end
			end
			gtphc_pkg::ACT_CANCEL: begin
				if (active_q) begin
					res_outcome = gtphc_pkg::OUTCOME_CANCELED;
				end
				active_n = 1'b0;
				mode_n   = gtphc_pkg::MODE_IDLE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			lin_q     <= res_lin;
			ang_q     <= res_ang;
			mode_q    <= mode_n;
			outcome_q <= res_outcome;
			err_q     <= res_err;
		end
	end

	assign out_valid     = out_valid_q;
	assign linear_cmd    = lin_q;
	assign angular_cmd   = ang_q;
	assign mode          = mode_q;
	assign outcome       = outcome_q;
	assign heading_error = err_q;

	`GTPHC_ASSERT_NEXT(a_tick_runs, clk, arst_n, accept && action == gtphc_pkg::ACT_TICK && active_q, state_q == gtphc_pkg::ST_RUN, "armed tick did not start a run")
	`GTPHC_ASSERT_NOW(a_one_item, clk, arst_n, 1'b1, $onehot0(tok_v), "more than one item in the cordic row")
	`GTPHC_ASSERT_NOW(a_end_in_run, clk, arst_n, ew_v_s2, state_q == gtphc_pkg::ST_RUN, "heading error ready outside a run")
	`GTPHC_ASSERT_NEXT(a_disarm, clk, arst_n, out_load && res_outcome != gtphc_pkg::OUTCOME_NONE, !active_q, "controller still armed after reached or canceled")

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int unsigned CORDIC_STEPS = 16;
	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = CORDIC_STEPS + 10;

	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam int CFG_RANDOM = 0;
	localparam int CFG_LOW = 1;
	localparam int CFG_HIGH = 2;

	// atan(2^-i) in q3.29
	localparam longint ATAN_Q29 [0:23] = '{
		421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
		8387925, 4194219, 2097141, 1048575, 524288, 262144,
		131072, 65536, 32768, 16384, 8192, 4096,
		2048, 1024, 512, 256, 128, 64
	};

	typedef struct packed {
		logic signed [15:0] lin;
		logic signed [15:0] ang;
		logic [1:0]         mode;
		logic [1:0]         outcome;
		logic signed [15:0] herr;
	} cmd_result_t;

	logic                                clk;
	logic                                arst_n = 1'b0;
	logic                                cfg_we = 1'b0;
	logic [gtphc_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
	logic [gtphc_pkg::CFG_DATA_W-1:0]    cfg_data = '0;
	logic                                in_valid = 1'b0;
	logic                                in_ready;
	logic [1:0]                          action = gtphc_pkg::ACT_START;
	logic signed [gtphc_pkg::POS_W-1:0]  pos_x = '0;
	logic signed [gtphc_pkg::POS_W-1:0]  pos_y = '0;
	logic signed [gtphc_pkg::HDG_W-1:0]  heading = '0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic signed [gtphc_pkg::CMD_W-1:0]  linear_cmd;
	logic signed [gtphc_pkg::CMD_W-1:0]  angular_cmd;
	logic [1:0]                          mode;
	logic [1:0]                          outcome;
	logic signed [gtphc_pkg::HDG_W-1:0]  heading_error;

	// controller mirror
	logic signed [31:0] goal_x, goal_y;
	logic [14:0]        hdg_tol, turn_spd, fwd_spd;
	logic [30:0]        dist_tol;
	bit                 armed;
	logic [1:0]         drv_mode;

	cmd_result_t expected_cmds[$];
	cmd_result_t want_cmd;

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_ticket = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int cycle_cnt = 0;
	int mismatches = 0;
	int items_sent = 0;
	int results_checked = 0;
	int arrivals_seen = 0;
	int cancels_seen = 0;
	int turns_seen = 0;
	int drives_seen = 0;

	go_to_point_heading_controller_unit #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.heading(heading),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.linear_cmd(linear_cmd),
		.angular_cmd(angular_cmd),
		.mode(mode),
		.outcome(outcome),
		.heading_error(heading_error)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// vectoring cordic, result rounded to q3.13
	function automatic longint cordic_bearing(input longint vx, input longint vy);
		longint x, y, z, t, xs, ys;
		int i;
		x = vx;
		y = vy;
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				t = x;
				x = y;
				y = -t;
				z = longint'(gtphc_pkg::HALF_PI_Q29);
			end else begin
				t = x;
				x = -y;
				y = t;
				z = -longint'(gtphc_pkg::HALF_PI_Q29);
			end
		end
		for (i = 0; i < CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_Q29[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_Q29[i];
			end
		end
		return (z + 32768) >>> 16;
	endfunction

	function automatic cmd_result_t predict_command(input logic [1:0] act,
			input logic signed [31:0] px, input logic signed [31:0] py,
			input logic signed [15:0] hd);
		cmd_result_t r;
		longint dx, dy, err, mag;
		logic [63:0] ax, ay, sq_a, sq_b;
		logic [65:0] sq_sum, tol_sq;
		r = '0;
		case (act)
			gtphc_pkg::ACT_START: begin
				armed = 1'b1;
				drv_mode = gtphc_pkg::MODE_IDLE;
			end
			gtphc_pkg::ACT_TICK: begin
				if (armed) begin
					dx = longint'(goal_x) - longint'(px);
					dy = longint'(goal_y) - longint'(py);
					ax = (dx < 0) ? -dx : dx;
					ay = (dy < 0) ? -dy : dy;
					sq_a = ax * ax;
					sq_b = ay * ay;
					// full-width sum, so a carry can never look close
					sq_sum = {2'b00, sq_a} + {2'b00, sq_b};
					tol_sq = dist_tol * dist_tol;
					if (sq_sum <= tol_sq) begin
						armed = 1'b0;
						drv_mode = gtphc_pkg::MODE_IDLE;
						r.outcome = gtphc_pkg::OUTCOME_REACHED;
					end else begin
						err = cordic_bearing(dx, dy) - longint'(hd);
						if (err > gtphc_pkg::PI_Q13) err = err - gtphc_pkg::TWO_PI_Q13;
						if (err > gtphc_pkg::PI_Q13) err = err - gtphc_pkg::TWO_PI_Q13;
						if (err < gtphc_pkg::NEG_PI_Q13) err = err + gtphc_pkg::TWO_PI_Q13;
						if (err < gtphc_pkg::NEG_PI_Q13) err = err + gtphc_pkg::TWO_PI_Q13;
						mag = (err < 0) ? -err : err;
						if (mag > longint'(hdg_tol)) begin
							drv_mode = gtphc_pkg::MODE_TURN;
							r.ang = (err > 0) ? {1'b0, turn_spd} : -{1'b0, turn_spd};
						end else begin
							drv_mode = gtphc_pkg::MODE_DRIVE;
							r.lin = {1'b0, fwd_spd};
						end
						r.herr = err[15:0];
					end
				end
			end
			gtphc_pkg::ACT_CANCEL: begin
				if (armed) r.outcome = gtphc_pkg::OUTCOME_CANCELED;
				armed = 1'b0;
				drv_mode = gtphc_pkg::MODE_IDLE;
			end
			default: ;
		endcase
		r.mode = drv_mode;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_cnt, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got %h expected %h",
				results_checked, name, got, want));
	endtask

	task automatic write_reg(input logic [gtphc_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic write_config(input logic signed [31:0] gx, input logic signed [31:0] gy,
			input logic [14:0] htol, input logic [30:0] dtol,
			input logic [14:0] tspd, input logic [14:0] fspd);
		write_reg(gtphc_pkg::REG_GOAL_X, gx);
		write_reg(gtphc_pkg::REG_GOAL_Y, gy);
		write_reg(gtphc_pkg::REG_HDG_TOL, {17'b0, htol});
		write_reg(gtphc_pkg::REG_DIST_TOL, {1'b0, dtol});
		write_reg(gtphc_pkg::REG_TURN_SPD, {17'b0, tspd});
		write_reg(gtphc_pkg::REG_FWD_SPD, {17'b0, fspd});
		cfg_we <= 1'b0;
		goal_x = gx;
		goal_y = gy;
		hdg_tol = htol;
		dist_tol = dtol;
		turn_spd = tspd;
		fwd_spd = fspd;
	endtask

	task automatic send_command(input logic [1:0] act, input logic signed [31:0] px,
			input logic signed [31:0] py, input logic signed [15:0] hd);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		pos_x <= px;
		pos_y <= py;
		heading <= hd;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// accepted at this edge; valid stays up for a back-to-back item
		expected_cmds.push_back(predict_command(act, px, py, hd));
		items_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_cmds.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_random_command();
		logic [1:0] act;
		logic signed [31:0] px, py;
		logic signed [15:0] hd;
		longint span;
		int r;
		r = $urandom_range(0, 99);
		if (!armed && r < 45) act = gtphc_pkg::ACT_START;
		else if (r < 12) act = gtphc_pkg::ACT_START;
		else if (r < 85) act = gtphc_pkg::ACT_TICK;
		else if (r < 95) act = gtphc_pkg::ACT_CANCEL;
		else act = ACT_UNUSED;
		span = longint'(dist_tol) + longint'(dist_tol >> 1) + 2;
		if (span > 1073741824) span = 1073741824;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				// around the arrival radius
				px = 32'(longint'(goal_x) - (longint'($urandom_range(0, 2 * span)) - span));
				py = 32'(longint'(goal_y) - (longint'($urandom_range(0, 2 * span)) - span));
			end
			3, 4, 5, 6: begin
				px = 32'(longint'(goal_x) + longint'($urandom_range(0, 2097152)) - 1048576);
				py = 32'(longint'(goal_y) + longint'($urandom_range(0, 2097152)) - 1048576);
			end
			default: begin
				px = $urandom;
				py = $urandom;
			end
		endcase
		case ($urandom_range(0, 9))
			0: hd = $urandom_range(0, 1) ? 16'sd25736 : -16'sd25736;
			1: hd = 16'($urandom);
			default: hd = 16'($urandom_range(0, 51472) - 25736);
		endcase
		send_command(act, px, py, hd);
	endtask

	task automatic load_random_config(input int kind);
		logic signed [31:0] gx, gy;
		logic [30:0] dtol;
		if ($urandom_range(0, 1)) begin
			gx = $urandom;
			gy = $urandom;
		end else begin
			gx = 32'($urandom_range(0, 33554432)) - 32'sd16777216;
			gy = 32'($urandom_range(0, 33554432)) - 32'sd16777216;
		end
		dtol = $urandom_range(0, 3) == 0 ? 31'($urandom) : 31'($urandom_range(0, 1048576));
		case (kind)
			CFG_LOW: write_config(gx, gy, 15'd0, 31'd0, 15'd0, 15'd0);
			CFG_HIGH: write_config(gx, gy, 15'd25736, 31'h7fffffff, 15'h7fff, 15'h7fff);
			default: write_config(gx, gy, 15'($urandom_range(0, 25736)), dtol,
				15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767)));
		endcase
	endtask

	task automatic test_idle_actions();
		send_command(gtphc_pkg::ACT_TICK, 32'sh7fffffff, 32'sh80000000, 16'sd25736);
		send_command(gtphc_pkg::ACT_CANCEL, 32'sd0, 32'sd0, -16'sd25736);
		send_command(ACT_UNUSED, -32'sd1, -32'sd1, 16'sh8000);
		drain_results();
	endtask

	task automatic test_arrival_and_cancel();
		send_command(gtphc_pkg::ACT_START, 32'sd0, 32'sd0, 16'sd0);
		// exactly on the arrival radius
		send_command(gtphc_pkg::ACT_TICK, 32'sd3277, 32'sd0, 16'sd0);
		send_command(gtphc_pkg::ACT_START, 32'sd0, 32'sd0, 16'sd0);
		send_command(gtphc_pkg::ACT_TICK, 32'sd3278, 32'sd0, 16'sd0);
		send_command(ACT_UNUSED, 32'sd5, 32'sd7, 16'sd100);
		send_command(gtphc_pkg::ACT_TICK, 32'sd0, -32'sd100000, 16'sd12868);
		// restart while already armed
		send_command(gtphc_pkg::ACT_START, 32'sd0, 32'sd0, 16'sd0);
		send_command(gtphc_pkg::ACT_CANCEL, 32'sd0, 32'sd0, 16'sd0);
		send_command(gtphc_pkg::ACT_CANCEL, 32'sd0, 32'sd0, 16'sd0);
		drain_results();
	endtask

	task automatic test_distance_extremes();
		write_config(32'sh7fffffff, 32'sd0, 15'd0, 31'd3277, 15'h7fff, 15'd0);
		send_command(gtphc_pkg::ACT_START, 32'sd0, 32'sd0, 16'sd0);
		// squared sum carries past 64 bits; the wider sum keeps it far outside the radius
		send_command(gtphc_pkg::ACT_TICK, 32'sh80000000, -32'sd92682, 16'sd0);
		send_command(gtphc_pkg::ACT_TICK, 32'sh80000000, 32'sh80000000, -16'sd25736);
		drain_results();
		write_config(32'sh80000000, 32'sh80000000, 15'd25736, 31'h7fffffff, 15'd0, 15'h7fff);
		send_command(gtphc_pkg::ACT_START, 32'sd0, 32'sd0, 16'sd0);
		send_command(gtphc_pkg::ACT_TICK, 32'sh7fffffff, 32'sh7fffffff, 16'sd0);
		send_command(gtphc_pkg::ACT_TICK, -32'sd1, 32'sh80000000, 16'sd0);
		drain_results();
	endtask

	task automatic test_heading_extremes();
		write_config(32'sd327680, -32'sd196608, 15'd286, 31'd3277, 15'd166, 15'd256);
		send_command(gtphc_pkg::ACT_START, 32'sd0, 32'sd0, 16'sd0);
		send_command(gtphc_pkg::ACT_TICK, 32'sd0, 32'sd0, 16'sh7fff);
		send_command(gtphc_pkg::ACT_TICK, 32'sd0, 32'sd0, 16'sh8000);
		send_command(gtphc_pkg::ACT_TICK, 32'sd0, 32'sd0, 16'sd25736);
		send_command(gtphc_pkg::ACT_TICK, 32'sd0, 32'sd0, -16'sd25736);
		// goal straight behind along -x
		send_command(gtphc_pkg::ACT_TICK, 32'sd393216, -32'sd196608, 16'sd0);
		drain_results();
	endtask

	task automatic run_random_phase(input int sender_idle, input int recv_stall,
			input int cfg_kind, input int n_items);
		load_random_config(cfg_kind);
		idle_pct = sender_idle;
		stall_pct <= recv_stall;
		repeat (n_items) send_random_command();
		drain_results();
	endtask

	task automatic test_random_traffic();
		run_random_phase(0, 0, CFG_RANDOM, 250);
		run_random_phase(57, 0, CFG_LOW, 250);
		run_random_phase(0, 57, CFG_RANDOM, 250);
		run_random_phase(10, 10, CFG_HIGH, 250);
	endtask

	task automatic test_backpressure();
		load_random_config(CFG_RANDOM);
		idle_pct = 0;
		stall_pct <= 0;
		hold_ticket <= hold_ticket + 1;
		repeat (40) send_random_command();
		drain_results();
	endtask

	// receiver: random stalls plus a long hold-off whenever the hold ticket changes
	always @(posedge clk) begin
		if (hold_seen != hold_ticket) begin
			hold_seen <= hold_ticket;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_cmds.size() == 0) begin
				report_mismatch("result with no item waiting");
			end else begin
				want_cmd = expected_cmds.pop_front();
				check_field("linear_cmd", linear_cmd, want_cmd.lin);
				check_field("angular_cmd", angular_cmd, want_cmd.ang);
				check_field("mode", {14'b0, mode}, {14'b0, want_cmd.mode});
				check_field("outcome", {14'b0, outcome}, {14'b0, want_cmd.outcome});
				check_field("heading_error", heading_error, want_cmd.herr);
				if (want_cmd.outcome == gtphc_pkg::OUTCOME_REACHED) arrivals_seen++;
				if (want_cmd.outcome == gtphc_pkg::OUTCOME_CANCELED) cancels_seen++;
				if (want_cmd.mode == gtphc_pkg::MODE_TURN) turns_seen++;
				if (want_cmd.mode == gtphc_pkg::MODE_DRIVE) drives_seen++;
			end
			results_checked++;
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
			expected_cmds.size());
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		goal_x = '0;
		goal_y = '0;
		hdg_tol = 15'd286;
		dist_tol = 31'd3277;
		turn_spd = 15'd166;
		fwd_spd = 15'd256;
		armed = 1'b0;
		drv_mode = gtphc_pkg::MODE_IDLE;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_actions();
		test_arrival_and_cancel();
		test_distance_extremes();
		test_heading_extremes();
		test_random_traffic();
		test_backpressure();

		$display("%0d items, %0d results checked: %0d arrivals, %0d cancels, %0d turn, %0d drive",
			items_sent, results_checked, arrivals_seen, cancels_seen, turns_seen, drives_seen);
		$display("configs at both extremes, idle and stall mixes, one long output hold-off");
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
